// ===== rtl/nrwc_pkg.sv =====
// Shared types and constants for the nonce replay window checker.
// Holds the command and status codes, payload structs and window limits.
// Depends on nothing.
package nrwc_pkg;

    // Width of the good, late and lost counters (they wrap at this width).
    localparam int COUNT_WIDTH  = 32;
    localparam int TOTAL_WIDTH  = 32;

    // Receive window geometry on the low nonce byte.
    localparam int HEADER_BYTES = 4;
    localparam int FULL_RANGE   = 256;
    localparam int HALF_RANGE   = 128;
    localparam int WINDOW_LATE  = -30;
    // Smallest forward distance (mod 256) that still counts as a late packet.
    localparam int LATE_MIN     = FULL_RANGE + WINDOW_LATE + 1;

    localparam int HIST_DEPTH   = 256;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);

    localparam int LOST_WIDTH   = 9;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_VERDICT = 2'd1,
        CMD_RESYNC  = 2'd2
    } nrwc_cmd_t;

    typedef enum logic [3:0] {
        ST_IN_ORDER   = 4'd0,
        ST_LATE       = 4'd1,
        ST_AFTER_LOSS = 4'd2,
        ST_SHORT      = 4'd3,
        ST_REPEAT     = 4'd4,
        ST_OUTSIDE    = 4'd5,
        ST_REPLAY     = 4'd6,
        ST_TAG_FAIL   = 4'd7,
        ST_NO_PENDING = 4'd8,
        ST_RESYNC     = 4'd9
    } nrwc_status_t;

    // Configuration register indexes.
    localparam logic CFG_RESYNC_LOW  = 1'b0;
    localparam logic CFG_RESYNC_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  nonce_byte;
        logic [15:0] packet_length;
        logic        tag_match;
    } nrwc_in_t;

    typedef struct packed {
        logic [3:0]             status;
        logic [63:0]            nonce_low;
        logic [63:0]            nonce_high;
        logic [TOTAL_WIDTH-1:0] good_total;
        logic [TOTAL_WIDTH-1:0] late_total;
        logic [TOTAL_WIDTH-1:0] lost_total;
    } nrwc_out_t;

    // Write request into the history memory.
    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
    } nrwc_hist_wr_t;

endpackage

// ===== rtl/nrwc_history.sv =====
// History memory of the nonce replay window checker: one byte per low nonce byte.
// Synchronous, registered read, same-cycle write forwarding, valid bits.
// Depends on nrwc_pkg.
module nrwc_history
    import nrwc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [HIST_AW-1:0] rd_addr,
    input  nrwc_hist_wr_t      wr,
    output logic [7:0]         rd_data
);

    logic [7:0]            mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] vld_reg;
    logic [7:0]            rd_mem_reg;
    logic                  rd_vld_reg;
    logic                  byp_hit_reg;
    logic [7:0]            byp_data_reg;

    // Entries never written read as zero, so reset only has to clear the valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // A write and a read of the same entry at the same edge return the new data.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_mem_reg   <= mem[rd_addr];
            rd_vld_reg   <= vld_reg[rd_addr];
            byp_hit_reg  <= wr.en && (wr.addr == rd_addr);
            byp_data_reg <= wr.data;
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : (rd_vld_reg ? rd_mem_reg : 8'd0);

endmodule

// ===== rtl/nonce_replay_window_checker.sv =====
// Top level of the nonce replay window checker.
// Classifies packet headers, applies tag verdicts and resyncs a 128-bit counter.
// Depends on nrwc_pkg and nrwc_history.

// The block accepts one command per clock cycle while the output register is not stalled.
// As the input transfer happens, the history memory is read at the packet's low
// nonce byte; in the resolve stage the command is resolved against the receive
// counter, the pending candidate and the history data, the state is updated and the
// result is loaded into the output register. Because every state update happens in
// that resolve stage, one command after another sees all effects of its predecessor;
// a verdict that writes a history entry in the same cycle a following header reads
// it is forwarded inside the history memory. The history starts out all zero through
// a valid bit per entry, so no clearing pass follows reset. Configuration writes on
// cfg_wr_en take effect at once and should only be issued while the block is idle.
module nonce_replay_window_checker
    import nrwc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  nrwc_in_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output nrwc_out_t   m_payload,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata
);

    // Pipeline control and the stage that waits for history read data.
    logic      s_fire;
    logic      s1_fire;
    logic      s1_valid_reg, s1_valid_next;
    nrwc_in_t  s1_item_reg;
    logic      m_valid_reg, m_valid_next;
    nrwc_out_t m_payload_reg, m_payload_next;

    // Configuration registers.
    logic [63:0] cfg_lo_reg, cfg_hi_reg;

    // Receive counter and the candidate that waits for its tag verdict.
    logic [63:0]            ctr_lo_reg, ctr_lo_next;
    logic [63:0]            ctr_hi_reg, ctr_hi_next;
    logic [63:0]            pend_lo_reg, pend_lo_next;
    logic [63:0]            pend_hi_reg, pend_hi_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_restore_reg, pend_restore_next;
    logic                   pend_late_reg, pend_late_next;
    logic [LOST_WIDTH-1:0]  pend_lost_reg, pend_lost_next;
    logic [COUNT_WIDTH-1:0] good_reg, good_next;
    logic [COUNT_WIDTH-1:0] late_reg, late_next;
    logic [COUNT_WIDTH-1:0] lost_reg, lost_next;

    // History memory interface.
    nrwc_hist_wr_t hist_wr;
    logic [7:0]    hist_data;

    // Header classification.
    logic [7:0]   hdr_byte;
    logic [7:0]   cur_byte;
    logic [7:0]   fwd_dist;
    logic         is_in_order;
    logic         is_repeat;
    logic         is_late;
    logic         is_gap;
    logic         step_up;
    logic         step_down;
    logic [119:0] upper;
    logic [119:0] upper_adj;
    logic [63:0]  cand_lo;
    logic [63:0]  cand_hi;
    logic         is_replay;

    // An item enters the resolve stage when that stage is empty or moves on itself;
    // the resolve stage moves on when the output register is free or being emptied.
    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    nrwc_history u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (s_payload.nonce_byte),
        .wr      (hist_wr),
        .rd_data (hist_data)
    );

    // The candidate keeps the counter's upper 120 bits, adjusted by one step of the
    // low byte when the received byte has wrapped relative to the counter's byte.
    // The distance is taken modulo 256; a distance of exactly half the range counts
    // as a gap only when the received byte is numerically above the counter's byte.
    always_comb begin
        hdr_byte    = s1_item_reg.nonce_byte;
        cur_byte    = ctr_lo_reg[7:0];
        fwd_dist    = hdr_byte - cur_byte;
        is_in_order = (fwd_dist == 8'd1);
        is_repeat   = (fwd_dist == 8'd0);
        is_late     = (fwd_dist >= 8'(LATE_MIN));
        is_gap      = ((fwd_dist != 8'd0) && (fwd_dist < 8'(HALF_RANGE)))
                      || ((fwd_dist == 8'(HALF_RANGE)) && (hdr_byte > cur_byte));
        step_up     = (is_in_order || is_gap) && (hdr_byte < cur_byte);
        step_down   = is_late && (hdr_byte > cur_byte);
        upper       = {ctr_hi_reg, ctr_lo_reg[63:8]};
        upper_adj   = upper + {{119{step_down}}, step_up | step_down};
        cand_lo     = {upper_adj[55:0], hdr_byte};
        cand_hi     = upper_adj[119:56];
        is_replay   = (hist_data == cand_lo[15:8]);
    end

    always_comb begin
        ctr_lo_next       = ctr_lo_reg;
        ctr_hi_next       = ctr_hi_reg;
        pend_lo_next      = pend_lo_reg;
        pend_hi_next      = pend_hi_reg;
        pend_valid_next   = pend_valid_reg;
        pend_restore_next = pend_restore_reg;
        pend_late_next    = pend_late_reg;
        pend_lost_next    = pend_lost_reg;
        good_next         = good_reg;
        late_next         = late_reg;
        lost_next         = lost_reg;
        hist_wr           = '0;
        m_payload_next    = m_payload_reg;

        s1_valid_next = s_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        m_valid_next  = s1_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        if (s1_fire) begin
            m_payload_next            = '0;
            m_payload_next.status     = ST_NO_PENDING;
            case (s1_item_reg.command)
                CMD_HEADER: begin
                    // Any header drops the candidate that was waiting.
                    pend_valid_next = 1'b0;
                    if (s1_item_reg.packet_length < 16'(HEADER_BYTES)) begin
                        m_payload_next.status = ST_SHORT;
                    end else if (is_in_order) begin
                        // In-order packets skip the history check.
                        pend_lo_next              = cand_lo;
                        pend_hi_next              = cand_hi;
                        pend_valid_next           = 1'b1;
                        pend_restore_next         = 1'b0;
                        pend_late_next            = 1'b0;
                        pend_lost_next            = '0;
                        m_payload_next.status     = ST_IN_ORDER;
                        m_payload_next.nonce_low  = cand_lo;
                        m_payload_next.nonce_high = cand_hi;
                    end else if (is_repeat) begin
                        m_payload_next.status = ST_REPEAT;
                    end else if (is_late || is_gap) begin
                        m_payload_next.nonce_low  = cand_lo;
                        m_payload_next.nonce_high = cand_hi;
                        if (is_replay) begin
                            m_payload_next.status = ST_REPLAY;
                        end else begin
                            pend_lo_next      = cand_lo;
                            pend_hi_next      = cand_hi;
                            pend_valid_next   = 1'b1;
                            pend_restore_next = is_late;
                            pend_late_next    = is_late;
                            // A late packet takes one back off the loss estimate.
                            pend_lost_next    = is_late ? '1 : {1'b0, fwd_dist - 8'd1};
                            m_payload_next.status = is_late ? ST_LATE : ST_AFTER_LOSS;
                        end
                    end else begin
                        m_payload_next.status = ST_OUTSIDE;
                    end
                end
                CMD_VERDICT: begin
                    if (pend_valid_reg) begin
                        pend_valid_next           = 1'b0;
                        m_payload_next.nonce_low  = pend_lo_reg;
                        m_payload_next.nonce_high = pend_hi_reg;
                        if (!s1_item_reg.tag_match) begin
                            m_payload_next.status = ST_TAG_FAIL;
                        end else begin
                            hist_wr.en   = 1'b1;
                            hist_wr.addr = pend_lo_reg[7:0];
                            hist_wr.data = pend_lo_reg[15:8];
                            // A late packet leaves the counter where it was.
                            if (!pend_restore_reg) begin
                                ctr_lo_next = pend_lo_reg;
                                ctr_hi_next = pend_hi_reg;
                            end
                            good_next = good_reg + COUNT_WIDTH'(1);
                            late_next = late_reg + COUNT_WIDTH'(pend_late_reg);
                            lost_next = lost_reg
                                        + {{(COUNT_WIDTH-LOST_WIDTH){pend_lost_reg[LOST_WIDTH-1]}},
                                           pend_lost_reg};
                            if (pend_late_reg) begin
                                m_payload_next.status = ST_LATE;
                            end else if (pend_lost_reg != '0) begin
                                m_payload_next.status = ST_AFTER_LOSS;
                            end else begin
                                m_payload_next.status = ST_IN_ORDER;
                            end
                        end
                    end
                end
                CMD_RESYNC: begin
                    ctr_lo_next               = cfg_lo_reg;
                    ctr_hi_next               = cfg_hi_reg;
                    pend_valid_next           = 1'b0;
                    m_payload_next.status     = ST_RESYNC;
                    m_payload_next.nonce_low  = cfg_lo_reg;
                    m_payload_next.nonce_high = cfg_hi_reg;
                end
                default: begin
                    // The unused command changes nothing.
                    m_payload_next.status = ST_NO_PENDING;
                end
            endcase
            // The totals always show the counts after this command.
            m_payload_next.good_total = TOTAL_WIDTH'(good_next);
            m_payload_next.late_total = TOTAL_WIDTH'(late_next);
            m_payload_next.lost_total = TOTAL_WIDTH'(lost_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            cfg_lo_reg       <= '0;
            cfg_hi_reg       <= '0;
            ctr_lo_reg       <= '0;
            ctr_hi_reg       <= '0;
            pend_lo_reg      <= '0;
            pend_hi_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            pend_restore_reg <= 1'b0;
            pend_late_reg    <= 1'b0;
            pend_lost_reg    <= '0;
            good_reg         <= '0;
            late_reg         <= '0;
            lost_reg         <= '0;
        end else begin
            s1_valid_reg     <= s1_valid_next;
            m_valid_reg      <= m_valid_next;
            ctr_lo_reg       <= ctr_lo_next;
            ctr_hi_reg       <= ctr_hi_next;
            pend_lo_reg      <= pend_lo_next;
            pend_hi_reg      <= pend_hi_next;
            pend_valid_reg   <= pend_valid_next;
            pend_restore_reg <= pend_restore_next;
            pend_late_reg    <= pend_late_next;
            pend_lost_reg    <= pend_lost_next;
            good_reg         <= good_next;
            late_reg         <= late_next;
            lost_reg         <= lost_next;
            if (cfg_wr_en) begin
                if (cfg_index == CFG_RESYNC_LOW) begin
                    cfg_lo_reg <= cfg_wdata;
                end
                if (cfg_index == CFG_RESYNC_HIGH) begin
                    cfg_hi_reg <= cfg_wdata;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg <= s_payload;
        end
        m_payload_reg <= m_payload_next;
    end

endmodule

// ===== dv/nrwc_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class for the nonce replay window checker testbench.
// It predicts each result from the accepted commands and checks the results as they leave.
// Depends on nrwc_pkg for the payload types and the status codes.
package nrwc_scoreboard_pkg;
    import nrwc_pkg::*;

    class nonce_window_scoreboard;
        // Resync registers and a private copy of the block's state.
        logic [63:0]  resync_low;
        logic [63:0]  resync_high;
        logic [127:0] rx_counter;
        logic [7:0]   seen_hi [HIST_DEPTH];
        logic [127:0] held_nonce;
        bit           held_valid;
        bit           held_restore;
        bit           held_late;
        logic [8:0]   held_lost;
        logic [31:0]  good_cnt;
        logic [31:0]  late_cnt;
        logic [31:0]  lost_cnt;

        nrwc_out_t    due_results[$];
        int           mismatches;
        int           results_seen;

        function new();
            resync_low   = '0;
            resync_high  = '0;
            rx_counter   = '0;
            held_nonce   = '0;
            held_valid   = 1'b0;
            held_restore = 1'b0;
            held_late    = 1'b0;
            held_lost    = '0;
            good_cnt     = '0;
            late_cnt     = '0;
            lost_cnt     = '0;
            mismatches   = 0;
            results_seen = 0;
            foreach (seen_hi[i]) seen_hi[i] = '0;
        endfunction

        function void set_register(logic idx, logic [63:0] val);
            if (idx == CFG_RESYNC_LOW)
                resync_low = val;
            else
                resync_high = val;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        // Packs a status and a nonce with the counts as they stand after the command.
        function nrwc_out_t make_result(nrwc_status_t st, logic [127:0] nonce);
            nrwc_out_t r;
            r.status     = st;
            r.nonce_low  = nonce[63:0];
            r.nonce_high = nonce[127:64];
            r.good_total = good_cnt;
            r.late_total = late_cnt;
            r.lost_total = lost_cnt;
            return r;
        endfunction

        function nrwc_out_t classify_header(nrwc_in_t it);
            logic [7:0]   b;
            logic [7:0]   cur;
            logic [127:0] cand;
            int           diff;
            int           lost;
            bit           late;
            bit           restore;
            nrwc_status_t st;
            b       = it.nonce_byte;
            cur     = rx_counter[7:0];
            cand    = {rx_counter[127:8], b};
            lost    = 0;
            late    = 1'b0;
            restore = 1'b0;
            held_valid = 1'b0;
            if (it.packet_length < HEADER_BYTES)
                return make_result(ST_SHORT, '0);
            if (8'(cur + 8'd1) == b) begin
                if (b < cur)
                    cand += 128'h100;
                st = ST_IN_ORDER;
            end else begin
                if (b == cur)
                    return make_result(ST_REPEAT, '0);
                diff = int'(b) - int'(cur);
                if (diff > HALF_RANGE)
                    diff -= FULL_RANGE;
                else if (diff < -HALF_RANGE)
                    diff += FULL_RANGE;
                if (diff > WINDOW_LATE && diff < 0) begin
                    // A late byte above the counter byte belongs to the previous lap.
                    if (b > cur)
                        cand -= 128'h100;
                    late    = 1'b1;
                    lost    = -1;
                    restore = 1'b1;
                    st      = ST_LATE;
                end else if (diff > 0) begin
                    if (b > cur) begin
                        lost = int'(b) - int'(cur) - 1;
                    end else begin
                        lost = FULL_RANGE - int'(cur) + int'(b) - 1;
                        cand += 128'h100;
                    end
                    st = ST_AFTER_LOSS;
                end else begin
                    return make_result(ST_OUTSIDE, '0);
                end
                if (seen_hi[cand[7:0]] == cand[15:8])
                    return make_result(ST_REPLAY, cand);
            end
            held_nonce   = cand;
            held_valid   = 1'b1;
            held_restore = restore;
            held_late    = late;
            held_lost    = 9'(lost);
            return make_result(st, cand);
        endfunction

        function nrwc_out_t apply_verdict(nrwc_in_t it);
            logic [31:0] delta;
            if (!held_valid)
                return make_result(ST_NO_PENDING, '0);
            held_valid = 1'b0;
            if (!it.tag_match)
                return make_result(ST_TAG_FAIL, held_nonce);
            seen_hi[held_nonce[7:0]] = held_nonce[15:8];
            if (!held_restore)
                rx_counter = held_nonce;
            delta    = {{23{held_lost[8]}}, held_lost};
            good_cnt = good_cnt + 32'd1;
            late_cnt = late_cnt + {31'd0, held_late};
            lost_cnt = lost_cnt + delta;
            if (held_late)
                return make_result(ST_LATE, held_nonce);
            if (held_lost != 0)
                return make_result(ST_AFTER_LOSS, held_nonce);
            return make_result(ST_IN_ORDER, held_nonce);
        endfunction

        // Called for every accepted command transfer.
        function void note_input(nrwc_in_t it);
            nrwc_out_t r;
            case (it.command)
                CMD_HEADER:  r = classify_header(it);
                CMD_VERDICT: r = apply_verdict(it);
                CMD_RESYNC: begin
                    rx_counter = {resync_high, resync_low};
                    held_valid = 1'b0;
                    r = make_result(ST_RESYNC, rx_counter);
                end
                default:     r = make_result(ST_NO_PENDING, '0);
            endcase
            due_results.push_back(r);
        endfunction

        task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("ERROR: result %0d %s: got %0h, want %0h",
                     results_seen, what, got, want);
        endtask

        // Called for every accepted result transfer.
        task check_result(nrwc_out_t got);
            nrwc_out_t want;
            results_seen++;
            if (due_results.size() == 0) begin
                flag_mismatch("arrived with nothing expected, status",
                              64'(got.status), '0);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.nonce_low !== want.nonce_low)
                flag_mismatch("nonce_low", got.nonce_low, want.nonce_low);
            if (got.nonce_high !== want.nonce_high)
                flag_mismatch("nonce_high", got.nonce_high, want.nonce_high);
            if (got.good_total !== want.good_total)
                flag_mismatch("good_total", 64'(got.good_total), 64'(want.good_total));
            if (got.late_total !== want.late_total)
                flag_mismatch("late_total", 64'(got.late_total), 64'(want.late_total));
            if (got.lost_total !== want.lost_total)
                flag_mismatch("lost_total", 64'(got.lost_total), 64'(want.lost_total));
        endtask
    endclass

endpackage

// ===== dv/tb_nonce_replay_window_checker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the nonce replay window checker.
// Drives directed and random header, verdict and resync commands and checks every result.
// Depends on nrwc_pkg, nrwc_scoreboard_pkg and the block's RTL.
module tb_nonce_replay_window_checker;
    import nrwc_pkg::*;
    import nrwc_scoreboard_pkg::*;

    // The fourth command code has no name in the package; the block must answer it
    // with a no-pending status and leave its state alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 275;
    // After this many results the receiver stops taking results for a long stretch.
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    // The slowest legal run is well under 1.5 ms; this leaves a wide margin.
    localparam int TIMEOUT_NS      = 6_000_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    nrwc_in_t    s_payload;
    logic        m_valid;
    logic        m_ready;
    nrwc_out_t   m_payload;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [63:0] cfg_wdata;

    nonce_window_scoreboard sb = new();

    // Shared controls: a quiet phase has no random gaps on either side, the tail keeps
    // the receiver ready while the last results drain.
    bit quiet = 1'b0;
    bit tail  = 1'b0;
    bit hold_done = 1'b0;
    int stall_left = 0;
    int items_sent = 0;

    nonce_replay_window_checker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic nrwc_in_t item(logic [1:0] cmd, logic [7:0] nb,
                                      logic [15:0] len, logic tag);
        nrwc_in_t it;
        it.command       = cmd;
        it.nonce_byte    = nb;
        it.packet_length = len;
        it.tag_match     = tag;
        return it;
    endfunction

    // Commands other than a header ignore most fields, so those get random values.
    function automatic nrwc_in_t noisy(logic [1:0] cmd, logic tag);
        return item(cmd, 8'($urandom_range(0, 255)), 16'($urandom), tag);
    endfunction

    // Lengths are mostly valid; a few are short and a few sit at the extremes.
    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'($urandom_range(0, 3));
        if (r < 8)
            return 16'hFFFF;
        if (r < 10)
            return 16'(HEADER_BYTES);
        return 16'($urandom_range(4, 1500));
    endfunction

    // The nonce byte is picked relative to the predicted counter byte so that every
    // class of the window is hit often: next in line, gaps, late, repeat and outside.
    function automatic logic [7:0] pick_nonce_byte();
        logic [7:0] cur;
        int r;
        cur = sb.rx_counter[7:0];
        r   = $urandom_range(0, 99);
        if (r < 40)
            return cur + 8'd1;
        if (r < 55)
            return cur + 8'($urandom_range(2, 8));
        if (r < 65)
            return cur + 8'($urandom_range(9, 128));
        if (r < 90)
            return cur - 8'($urandom_range(1, 29));
        if (r < 93)
            return cur;
        if (r < 97)
            return cur - 8'($urandom_range(30, 128));
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one command and returns at the edge where the transfer happens. Valid is
    // only lowered when a gap is wanted, so back-to-back commands keep it high.
    task automatic send(nrwc_in_t it);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has come out and the
    // pipeline is surely empty before the registers change.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both resync registers on consecutive edges; only called while idle.
    task automatic load_resync(logic [63:0] low, logic [63:0] high);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RESYNC_LOW;
        cfg_wdata <= low;
        @(posedge aclk);
        sb.set_register(CFG_RESYNC_LOW, low);
        cfg_index <= CFG_RESYNC_HIGH;
        cfg_wdata <= high;
        @(posedge aclk);
        sb.set_register(CFG_RESYNC_HIGH, high);
        cfg_wr_en <= 1'b0;
    endtask

    // Most random traffic is a header and then its verdict, the only way to fill the
    // history and, besides resyncs, to move the counter. The rest breaks that pattern:
    // lone headers, lone verdicts, resyncs, the unused code and fully random commands.
    task automatic random_sequence();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            send(item(CMD_HEADER, pick_nonce_byte(), pick_length(), 1'($urandom)));
            send(noisy(CMD_VERDICT, $urandom_range(0, 9) != 0));
        end else if (kind < 78) begin
            send(item(CMD_HEADER, pick_nonce_byte(), pick_length(), 1'($urandom)));
        end else if (kind < 86) begin
            send(noisy(CMD_VERDICT, 1'($urandom)));
        end else if (kind < 91) begin
            send(noisy(CMD_RESYNC, 1'($urandom)));
        end else if (kind < 95) begin
            send(noisy(CMD_UNUSED, 1'($urandom)));
        end else begin
            send(noisy(2'($urandom_range(0, 3)), 1'($urandom)));
        end
    endtask

    // Result side: checks every result transfer and drives ready with random stalls,
    // one long hold-off that backs the block up, and no random stalls in quiet phases.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result(m_payload);
            if (!hold_done && sb.results_seen >= HOLD_OFF_AT) begin
                hold_done  = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (tail) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = idle_len();
                m_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial begin
        logic [63:0] phase_low  [PHASES];
        logic [63:0] phase_high [PHASES];
        int target;

        // Counter settings per phase: a full 128-bit wrap, all zero, a low half that
        // borrows from the high half on late packets, random, and the two half extremes.
        phase_low[0]  = 64'hFFFF_FFFF_FFFF_FFF0;  phase_high[0] = '1;
        phase_low[1]  = '0;                       phase_high[1] = '0;
        phase_low[2]  = 64'h0000_0000_0000_0005;  phase_high[2] = {$urandom, $urandom};
        phase_low[3]  = {$urandom, $urandom};     phase_high[3] = {$urandom, $urandom};
        phase_low[4]  = '1;                       phase_high[4] = '0;
        phase_low[5]  = '0;                       phase_high[5] = '1;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_RESYNC_LOW;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. The counter starts at 0x1280 so that byte 1 is nonzero and
        // fresh history entries do not look like replays.
        load_resync(64'h0000_0000_0000_1280, 64'h8000_0000_0000_0001);
        send(item(CMD_RESYNC, 8'h00, 16'h0000, 1'b0));
        send(item(CMD_VERDICT, 8'h00, 16'd0, 1'b1));       // nothing pending
        send(item(CMD_UNUSED, 8'hFF, 16'hFFFF, 1'b1));     // unused command code
        send(item(CMD_HEADER, 8'h81, 16'd0, 1'b0));        // empty packet is short
        send(item(CMD_HEADER, 8'h81, 16'd3, 1'b0));        // one byte below the header
        send(item(CMD_HEADER, 8'h80, 16'd4, 1'b1));        // same byte as the counter
        send(item(CMD_HEADER, 8'h81, 16'hFFFF, 1'b0));     // next in line, longest packet
        send(item(CMD_VERDICT, 8'h00, 16'd0, 1'b1));
        send(item(CMD_HEADER, 8'h90, 16'd4, 1'b0));        // gap of fourteen
        send(item(CMD_VERDICT, 8'hFF, 16'hFFFF, 1'b1));
        send(item(CMD_HEADER, 8'h85, 16'd64, 1'b0));       // late inside the window
        send(item(CMD_VERDICT, 8'h00, 16'd0, 1'b1));
        send(item(CMD_HEADER, 8'h85, 16'd64, 1'b0));       // same late packet again
        send(item(CMD_HEADER, 8'h72, 16'd64, 1'b0));       // thirty back: outside
        send(item(CMD_HEADER, 8'h73, 16'd64, 1'b0));       // twenty-nine back: late
        send(item(CMD_VERDICT, 8'h00, 16'd0, 1'b0));       // tag failure drops it
        send(item(CMD_HEADER, 8'h10, 16'd64, 1'b0));       // half a lap back: outside
        send(item(CMD_HEADER, 8'h0F, 16'd64, 1'b0));       // ahead across the byte wrap
        send(item(CMD_HEADER, 8'h0F, 16'd64, 1'b0));       // second header replaces it
        send(item(CMD_VERDICT, 8'h00, 16'd0, 1'b1));
        send(item(CMD_VERDICT, 8'h00, 16'd0, 1'b1));       // already consumed
        send(item(CMD_HEADER, 8'h10, 16'd64, 1'b0));
        send(item(CMD_RESYNC, 8'h00, 16'd0, 1'b0));        // resync drops the candidate
        send(item(CMD_VERDICT, 8'h00, 16'd0, 1'b1));
        drain();

        // Random part, one counter setting per phase; the second phase runs without
        // any gaps on either side and also takes the long hold-off.
        target = items_sent;
        for (int p = 0; p < PHASES; p++) begin
            quiet = (p == 1);
            load_resync(phase_low[p], phase_high[p]);
            send(noisy(CMD_RESYNC, 1'($urandom)));
            target += ITEMS_PER_PHASE;
            while (items_sent < target)
                random_sequence();
            drain();
        end

        // Keep the receiver ready for a while to catch any stray result.
        tail = 1'b1;
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
